// ----- sv/fpha_pkg.sv -----
// Shared types and constants for the fit policy heap allocator.
// Used by fpha_ctrl, fpha_dp and fit_policy_heap_allocator_top; no dependencies.
`default_nettype none
package fpha_pkg;

  localparam int OFF_W      = 20;
  localparam int SIZE_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam int HEAP_RESET = 1048576;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int ADDR_BITS_DEF  = 20;

  localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 2'd1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_NEXT  = 2'd3
  } fit_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_ALLOC = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_INIT,
    OP_ACCEPT,
    OP_SCAN,
    OP_PREP_UP,
    OP_SHIFT_UP,
    OP_SPLIT_TAIL,
    OP_GRANT,
    OP_MERGE,
    OP_SHIFT_DN,
    OP_RESULT
  } dp_op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_SHIFT_UP,
    S_SPLIT_TAIL,
    S_GRANT,
    S_MERGE,
    S_SHIFT_DN,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t res;
  } ctl_t;

  typedef struct packed {
    logic heap_wr;
    logic is_free;
    logic found;
    logic zero_req;
    logic split;
    logic full;
    logic merge;
    logic walk_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- sv/fpha_ram.sv -----
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module fpha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- sv/fpha_ctrl.sv -----
// Sequencer for the allocator: scan, shift, split, merge and result steps.
// Depends on fpha_pkg; drives fpha_dp through ctl_t, reads sts_t.
`default_nettype none
module fpha_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire fpha_pkg::sts_t  sts,
  output logic                 in_stall,
  output logic                 cfg_ready,
  output fpha_pkg::ctl_t       ctl
);

  fpha_pkg::state_t  state_r, state_nxt;
  fpha_pkg::status_t res_r, res_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fpha_pkg::S_INIT;
      res_r   <= fpha_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      res_r   <= res_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    res_nxt   = res_r;
    ctl.op    = fpha_pkg::OP_NONE;
    ctl.res   = res_r;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      fpha_pkg::S_INIT: begin
        ctl.op    = fpha_pkg::OP_INIT;
        state_nxt = fpha_pkg::S_IDLE;
      end
      fpha_pkg::S_IDLE: begin
        in_stall  = 1'b0;
        cfg_ready = !in_valid;
        if (in_valid) begin
          ctl.op    = fpha_pkg::OP_ACCEPT;
          state_nxt = fpha_pkg::S_SCAN;
        end else if (sts.heap_wr) begin
          state_nxt = fpha_pkg::S_INIT;
        end
      end
      fpha_pkg::S_SCAN: begin
        ctl.op = fpha_pkg::OP_SCAN;
        if (sts.walk_done) begin
          state_nxt = fpha_pkg::S_DECIDE;
        end
      end
      fpha_pkg::S_DECIDE: begin
        if (sts.is_free) begin
          if (!sts.found) begin
            res_nxt   = fpha_pkg::ST_NOT_ALLOC;
            state_nxt = fpha_pkg::S_DONE;
          end else begin
            state_nxt = fpha_pkg::S_MERGE;
          end
        end else begin
          priority if (!sts.found) begin
            res_nxt   = fpha_pkg::ST_NO_FIT;
            state_nxt = fpha_pkg::S_DONE;
          end else if (sts.zero_req) begin
            res_nxt   = fpha_pkg::ST_OK;
            state_nxt = fpha_pkg::S_DONE;
          end else if (sts.split && sts.full) begin
            res_nxt   = fpha_pkg::ST_FULL;
            state_nxt = fpha_pkg::S_DONE;
          end else if (sts.split) begin
            ctl.op    = fpha_pkg::OP_PREP_UP;
            state_nxt = fpha_pkg::S_SHIFT_UP;
          end else begin
            state_nxt = fpha_pkg::S_GRANT;
          end
        end
      end
      fpha_pkg::S_SHIFT_UP: begin
        ctl.op = fpha_pkg::OP_SHIFT_UP;
        if (sts.walk_done) begin
          state_nxt = fpha_pkg::S_SPLIT_TAIL;
        end
      end
      fpha_pkg::S_SPLIT_TAIL: begin
        ctl.op    = fpha_pkg::OP_SPLIT_TAIL;
        state_nxt = fpha_pkg::S_GRANT;
      end
      fpha_pkg::S_GRANT: begin
        ctl.op    = fpha_pkg::OP_GRANT;
        res_nxt   = fpha_pkg::ST_OK;
        state_nxt = fpha_pkg::S_DONE;
      end
      fpha_pkg::S_MERGE: begin
        ctl.op    = fpha_pkg::OP_MERGE;
        res_nxt   = fpha_pkg::ST_OK;
        state_nxt = sts.merge ? fpha_pkg::S_SHIFT_DN : fpha_pkg::S_DONE;
      end
      fpha_pkg::S_SHIFT_DN: begin
        ctl.op = fpha_pkg::OP_SHIFT_DN;
        if (sts.walk_done) begin
          state_nxt = fpha_pkg::S_DONE;
        end
      end
      fpha_pkg::S_DONE: begin
        if (sts.out_free) begin
          ctl.op    = fpha_pkg::OP_RESULT;
          state_nxt = fpha_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = fpha_pkg::S_INIT;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/fpha_dp.sv -----
// Datapath: block table RAM, scan trackers, config registers, result register.
// Depends on fpha_pkg and fpha_ram; steered by fpha_ctrl through ctl_t.
`default_nettype none
module fpha_dp #(
  parameter int MAX_BLOCKS = fpha_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = fpha_pkg::ADDR_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire fpha_pkg::ctl_t                     ctl,
  output fpha_pkg::sts_t                          sts,
  input  wire logic                               in_cmd,
  input  wire logic [fpha_pkg::SIZE_W-1:0]        in_req_size,
  input  wire logic [fpha_pkg::OFF_W-1:0]         in_free_offset,
  input  wire logic                               cfg_valid,
  input  wire logic                               cfg_ready,
  input  wire logic [fpha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fpha_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_status,
  output logic [fpha_pkg::OFF_W-1:0]              out_alloc_offset,
  output logic [fpha_pkg::SIZE_W-1:0]             out_freed_size
);

  localparam int AW   = ADDR_BITS;
  localparam int LW   = ADDR_BITS + 1;
  localparam int CW   = (LW > fpha_pkg::SIZE_W) ? LW : fpha_pkg::SIZE_W;
  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int NW   = $clog2(MAX_BLOCKS + 1);
  localparam int WW   = AW + 2 * LW;
  localparam logic [CW-1:0] HEAP_CAP = CW'(1) << AW;
  localparam logic [CW-1:0] RST_EXT  = CW'(fpha_pkg::HEAP_RESET);
  localparam logic [CW-1:0] RST_CLIP = (RST_EXT > HEAP_CAP) ? HEAP_CAP : RST_EXT;
  localparam logic [NW-1:0] MAX_N    = NW'(MAX_BLOCKS);

  fpha_pkg::fit_t          fit_mode_r;
  logic [LW-1:0]           heap_r;
  logic [NW-1:0]           count_r;
  logic [AW-1:0]           rover_r;
  logic                    rover_vld_r;
  logic                    cmd_r;
  logic [fpha_pkg::SIZE_W-1:0] req_r;
  logic [fpha_pkg::OFF_W-1:0]  off_r;
  logic [NW-1:0]           ptr_r;
  logic                    rd_vld_r;
  logic [IW-1:0]           rd_idx_r;

  logic                    pick_vld_r, pick_aft_r;
  logic [IW-1:0]           pick_idx_r;
  logic [AW-1:0]           pick_start_r;
  logic [LW-1:0]           pick_len_r, pick_used_r;
  logic [AW-1:0]           last_start_r;
  logic [LW-1:0]           last_len_r, last_used_r;
  logic                    pv_ok_r, nx_ok_r;
  logic [AW-1:0]           pv_start_r;
  logic [LW-1:0]           pv_len_r, pv_used_r, nx_len_r, nx_used_r;

  logic                    out_valid_r;
  logic [1:0]              status_r;
  logic [fpha_pkg::OFF_W-1:0]  alloc_off_r;
  logic [fpha_pkg::SIZE_W-1:0] freed_r;

  logic                    we;
  logic [IW-1:0]           waddr;
  logic [WW-1:0]           wdata, rdata;
  logic                    issue;

  logic [AW-1:0]           e_start;
  logic [LW-1:0]           e_len, e_used;
  logic                    fit, after, better, take, hit;
  logic                    pv_free, nx_free;
  logic [1:0]              gone;
  logic [IW-1:0]           lo_idx;
  logic [AW-1:0]           lo_start;
  logic [LW-1:0]           merged_len;
  logic [CW-1:0]           cfg_ext, heap_clip;
  logic                    split;
  logic [LW-1:0]           req_l;

  assign e_start = rdata[WW-1 -: AW];
  assign e_len   = rdata[2*LW-1 -: LW];
  assign e_used  = rdata[LW-1:0];
  assign req_l   = LW'(req_r);

  assign fit    = (e_used == '0) && (CW'(e_len) >= CW'(req_r));
  assign after  = !rover_vld_r || (e_start >= rover_r);
  assign better = ((fit_mode_r == fpha_pkg::FIT_BEST)  && (e_len < pick_len_r)) ||
                  ((fit_mode_r == fpha_pkg::FIT_WORST) && (e_len > pick_len_r));
  assign hit    = (CW'(e_start) == CW'(off_r)) && (e_used != '0);

  always_comb begin
    unique case (fit_mode_r)
      fpha_pkg::FIT_FIRST: take = fit && !pick_vld_r;
      fpha_pkg::FIT_BEST,
      fpha_pkg::FIT_WORST: take = fit && (!pick_vld_r || better);
      fpha_pkg::FIT_NEXT:  take = fit && (!pick_vld_r || (after && !pick_aft_r));
      default:             take = 1'b0;
    endcase
  end

  assign pv_free    = pv_ok_r && (pv_used_r == '0);
  assign nx_free    = nx_ok_r && (nx_used_r == '0);
  assign gone       = {1'b0, pv_free} + {1'b0, nx_free};
  assign lo_idx     = pv_free ? IW'(pick_idx_r - 1'b1) : pick_idx_r;
  assign lo_start   = pv_free ? pv_start_r : pick_start_r;
  assign merged_len = (pv_free ? pv_len_r : '0) + pick_len_r + (nx_free ? nx_len_r : '0);
  assign split      = CW'(pick_len_r) > CW'(req_r);

  assign cfg_ext   = CW'(cfg_data);
  assign heap_clip = (cfg_ext == '0) ? CW'(1) : ((cfg_ext > HEAP_CAP) ? HEAP_CAP : cfg_ext);

  always_comb begin
    issue = 1'b0;
    unique case (ctl.op)
      fpha_pkg::OP_SCAN:     issue = ptr_r < count_r;
      fpha_pkg::OP_SHIFT_UP: issue = ptr_r > NW'(pick_idx_r);
      fpha_pkg::OP_SHIFT_DN: issue = ptr_r < NW'(count_r + NW'(gone));
      default:               issue = 1'b0;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = pick_idx_r;
    wdata = {pick_start_r, req_l, req_l};
    unique case (ctl.op)
      fpha_pkg::OP_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = {AW'(0), heap_r, LW'(0)};
      end
      fpha_pkg::OP_SHIFT_UP: begin
        we    = rd_vld_r;
        waddr = IW'(rd_idx_r + 1'b1);
        wdata = rdata;
      end
      fpha_pkg::OP_SPLIT_TAIL: begin
        we    = 1'b1;
        waddr = IW'(pick_idx_r + 1'b1);
        wdata = {AW'(CW'(pick_start_r) + CW'(req_r)),
                 LW'(CW'(pick_len_r) - CW'(req_r)), LW'(0)};
      end
      fpha_pkg::OP_GRANT: begin
        we = 1'b1;
      end
      fpha_pkg::OP_MERGE: begin
        we    = 1'b1;
        waddr = lo_idx;
        wdata = {lo_start, merged_len, LW'(0)};
      end
      fpha_pkg::OP_SHIFT_DN: begin
        we    = rd_vld_r;
        waddr = IW'(rd_idx_r - IW'(gone));
        wdata = rdata;
      end
      default: we = 1'b0;
    endcase
  end

  fpha_ram #(.WIDTH(WW), .DEPTH(MAX_BLOCKS)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ptr_r[IW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_mode_r  <= fpha_pkg::FIT_FIRST;
      heap_r      <= LW'(RST_CLIP);
      count_r     <= NW'(1);
      rover_r     <= '0;
      rover_vld_r <= 1'b1;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r <= issue;
      if (ctl.op == fpha_pkg::OP_RESULT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == fpha_pkg::REG_FIT_MODE) begin
          fit_mode_r <= fpha_pkg::fit_t'(cfg_data[1:0]);
        end else if (cfg_index == fpha_pkg::REG_HEAP_SIZE) begin
          heap_r <= LW'(heap_clip);
        end
      end
      unique case (ctl.op)
        fpha_pkg::OP_INIT: begin
          count_r     <= NW'(1);
          rover_r     <= '0;
          rover_vld_r <= 1'b1;
        end
        fpha_pkg::OP_ACCEPT: begin
          if (in_cmd == fpha_pkg::CMD_FREE && rover_vld_r &&
              CW'(rover_r) == CW'(in_free_offset)) begin
            rover_vld_r <= 1'b0;
          end
        end
        fpha_pkg::OP_GRANT: begin
          if (split) begin
            count_r <= NW'(count_r + 1'b1);
          end
          if (fit_mode_r == fpha_pkg::FIT_NEXT) begin
            rover_r     <= pick_start_r;
            rover_vld_r <= 1'b1;
          end
        end
        fpha_pkg::OP_MERGE: begin
          count_r <= NW'(count_r - NW'(gone));
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_idx_r <= ptr_r[IW-1:0];
    end
    unique case (ctl.op)
      fpha_pkg::OP_ACCEPT: begin
        cmd_r      <= in_cmd;
        req_r      <= in_req_size;
        off_r      <= in_free_offset;
        ptr_r      <= '0;
        pick_vld_r <= 1'b0;
        pick_aft_r <= 1'b0;
        nx_ok_r    <= 1'b0;
      end
      fpha_pkg::OP_SCAN: begin
        if (issue) begin
          ptr_r <= NW'(ptr_r + 1'b1);
        end
        if (rd_vld_r) begin
          last_start_r <= e_start;
          last_len_r   <= e_len;
          last_used_r  <= e_used;
          if (cmd_r == fpha_pkg::CMD_ALLOC) begin
            if (take) begin
              pick_vld_r   <= 1'b1;
              pick_aft_r   <= after;
              pick_idx_r   <= rd_idx_r;
              pick_start_r <= e_start;
              pick_len_r   <= e_len;
            end
          end else if (!pick_vld_r && hit) begin
            pick_vld_r   <= 1'b1;
            pick_idx_r   <= rd_idx_r;
            pick_start_r <= e_start;
            pick_len_r   <= e_len;
            pick_used_r  <= e_used;
            pv_ok_r      <= rd_idx_r != '0;
            pv_start_r   <= last_start_r;
            pv_len_r     <= last_len_r;
            pv_used_r    <= last_used_r;
          end else if (pick_vld_r && !nx_ok_r &&
                       rd_idx_r == IW'(pick_idx_r + 1'b1)) begin
            nx_ok_r   <= 1'b1;
            nx_len_r  <= e_len;
            nx_used_r <= e_used;
          end
        end
      end
      fpha_pkg::OP_PREP_UP: begin
        ptr_r <= NW'(count_r - 1'b1);
      end
      fpha_pkg::OP_SHIFT_UP: begin
        if (issue) begin
          ptr_r <= NW'(ptr_r - 1'b1);
        end
      end
      fpha_pkg::OP_MERGE: begin
        ptr_r <= NW'(NW'(lo_idx) + 1'b1 + NW'(gone));
      end
      fpha_pkg::OP_SHIFT_DN: begin
        if (issue) begin
          ptr_r <= NW'(ptr_r + 1'b1);
        end
      end
      fpha_pkg::OP_RESULT: begin
        status_r    <= ctl.res;
        alloc_off_r <= (ctl.res == fpha_pkg::ST_OK && cmd_r == fpha_pkg::CMD_ALLOC) ?
                       fpha_pkg::OFF_W'(pick_start_r) : '0;
        freed_r     <= (ctl.res == fpha_pkg::ST_OK && cmd_r == fpha_pkg::CMD_FREE) ?
                       fpha_pkg::SIZE_W'(pick_used_r) : '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    sts.heap_wr   = cfg_valid && cfg_ready && (cfg_index == fpha_pkg::REG_HEAP_SIZE);
    sts.is_free   = cmd_r == fpha_pkg::CMD_FREE;
    sts.found     = pick_vld_r;
    sts.zero_req  = req_r == '0;
    sts.split     = split;
    sts.full      = count_r >= MAX_N;
    sts.merge     = gone != 2'd0;
    sts.walk_done = !issue && !rd_vld_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_alloc_offset = alloc_off_r;
  assign out_freed_size   = freed_r;

endmodule
`default_nettype wire

// ----- sv/fit_policy_heap_allocator_top.sv -----
// From acceptance to out_valid the allocator scans every entry through the registered-read RAM,
// then shifts entries for a split or merge. Flow: one transaction in flight; the next is taken
// in the cycle out_valid rises; a stalled result holds back only the following result.
// Reset (rst_n low, synchronous): fit_mode first fit, heap_size 1048576, one free block written
// in the cycle after reset and after each heap_size write. Uses fpha_pkg, fpha_ctrl, fpha_dp.
`default_nettype none
module fit_policy_heap_allocator_top #(
  parameter int MAX_BLOCKS = fpha_pkg::MAX_BLOCKS_DEF,
  parameter int ADDR_BITS  = fpha_pkg::ADDR_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               in_cmd,
  input  wire logic [fpha_pkg::SIZE_W-1:0]        in_req_size,
  input  wire logic [fpha_pkg::OFF_W-1:0]         in_free_offset,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [1:0]                              out_status,
  output logic [fpha_pkg::OFF_W-1:0]              out_alloc_offset,
  output logic [fpha_pkg::SIZE_W-1:0]             out_freed_size,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [fpha_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fpha_pkg::CFG_DATA_W-1:0]    cfg_data
);

  fpha_pkg::ctl_t ctl;
  fpha_pkg::sts_t sts;

  fpha_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .sts       (sts),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .ctl       (ctl)
  );

  fpha_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_req_size      (in_req_size),
    .in_free_offset   (in_free_offset),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_alloc_offset (out_alloc_offset),
    .out_freed_size   (out_freed_size)
  );

endmodule
`default_nettype wire
